// ===== hw/rtl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// shared widths, reset values, register codes and channel structs
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

    localparam int DIGIT_W = 4;
    localparam int LEN_W   = 16;
    localparam int KEEP_W  = 5;
    localparam int VALUE_W = 54;
    localparam int TOTAL_W = 64;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    localparam logic [DIGIT_W-1:0] MAX_DIGIT         = 4'd9;
    localparam logic [LEN_W-1:0]   LINE_LENGTH_RESET = 16'd100;
    localparam logic [KEEP_W-1:0]  KEEP_COUNT_RESET  = 5'd12;

    typedef enum logic [0:0] {
        REG_LINE_LENGTH = 1'b0,
        REG_KEEP_COUNT  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]  line_length;
        logic [KEEP_W-1:0] keep_count;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
    } step_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/max_digit_subsequence_picker.sv =====
// ----------------------------------------------------------------------------
// max_digit_subsequence_picker
// largest keep_count-digit subsequence per line with a saturating total
// ----------------------------------------------------------------------------
// One decimal digit is taken per cycle with no bubbles while the output is not
// stalled. A digit is held in the input register, then every held digit is
// compared with it in parallel, the popped depth is found, and the prefix value
// at that depth is extended by the new digit; the line value therefore needs no
// final fold. The word for a finished line passes from the input register
// through the stack result register into the output word register, with
// running_total saturating at all ones. Digits above nine count as nine.
// ----------------------------------------------------------------------------
`default_nettype none

module max_digit_subsequence_picker
    import msp_pkg::*;
#(
    parameter int MAX_KEEP = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [APB_W-1:0]    pwdata,
    output logic      [APB_W-1:0]    prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [DIGIT_W-1:0]  digit,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [VALUE_W-1:0]  line_value,
    output logic      [TOTAL_W-1:0]  running_total
);

    cfg_t               cfg;
    res_t               res;
    logic               stack_ready;
    logic               total_ready;
    logic               in_valid_reg;
    logic [DIGIT_W-1:0] in_digit_reg;
    logic               accept;
    step_t              step;

    assign in_stall = in_valid_reg && !stack_ready;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_digit_reg <= digit;
        end
    end

    assign step.valid = in_valid_reg;
    assign step.digit = in_digit_reg;

    msp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msp_stack #(
        .MAX_KEEP (MAX_KEEP)
    ) u_stack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .out_ready (total_ready),
        .ready     (stack_ready),
        .res       (res)
    );

    msp_total u_total
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .ready         (total_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_value    (line_value),
        .running_total (running_total)
    );

`ifndef SYNTHESIS
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && res.valid)
        else $error("input stalled with nothing pending");

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/msp_cfg.sv =====
// ----------------------------------------------------------------------------
// msp_cfg
// apb register file holding line length and keep count
// ----------------------------------------------------------------------------
`default_nettype none

module msp_cfg
    import msp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic      [APB_W-1:0]  prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [LEN_W-1:0]  line_length_reg;
    logic [KEEP_W-1:0] keep_count_reg;
    logic              wr_en;
    reg_idx_t          sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= LINE_LENGTH_RESET;
            keep_count_reg  <= KEEP_COUNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_LINE_LENGTH: line_length_reg <= pwdata[LEN_W-1:0];
                REG_KEEP_COUNT:  keep_count_reg  <= pwdata[KEEP_W-1:0];
                default:         line_length_reg <= line_length_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_LINE_LENGTH: prdata = APB_W'(line_length_reg);
            REG_KEEP_COUNT:  prdata = APB_W'(keep_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.line_length = line_length_reg;
    assign cfg.keep_count  = keep_count_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/msp_stack.sv =====
// ----------------------------------------------------------------------------
// msp_stack
// greedy digit stack with per-depth prefix values and line result register
// ----------------------------------------------------------------------------
`default_nettype none

module msp_stack
    import msp_pkg::*;
#(
    parameter int MAX_KEEP = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  step_t     step,
    input  wire logic out_ready,
    output logic      ready,
    output res_t      res
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam logic [KEEP_W-1:0] KEEP_MAX = KEEP_W'(MAX_KEEP);

    logic [DIGIT_W-1:0] held_reg [MAX_KEEP];
    logic [VALUE_W-1:0] pref_reg [MAX_KEEP];
    logic [CW-1:0]      count_reg, count_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               res_valid_reg;
    logic [VALUE_W-1:0] res_value_reg;

    logic [DIGIT_W-1:0] d;
    logic [LEN_W-1:0]   len_eff;
    logic [KEEP_W-1:0]  k5;
    logic [CW-1:0]      k_eff;
    logic               last;
    logic [LEN_W-1:0]   rem;
    logic [MAX_KEEP-1:0] pop_ok;
    logic [CW-1:0]      nc;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] new_val;
    logic [VALUE_W-1:0] line_val;
    logic               push;
    logic               adv;
    logic               res_adv;

    assign res_adv = res_valid_reg && out_ready;
    assign ready   = !res_valid_reg || out_ready;
    assign adv     = step.valid && ready;

    always_comb
    begin
        d       = (step.digit > MAX_DIGIT) ? MAX_DIGIT : step.digit;
        len_eff = (cfg.line_length == '0) ? LEN_W'(1) : cfg.line_length;
        k5      = cfg.keep_count;
        if (k5 == '0)
        begin
            k5 = KEEP_W'(1);
        end
        if (k5 > KEEP_MAX)
        begin
            k5 = KEEP_MAX;
        end
        k_eff = CW'(k5);
        last  = pos_reg >= (len_eff - LEN_W'(1));
        rem   = last ? LEN_W'(1) : (len_eff - pos_reg);

        // keep the deepest entry that survives, popping everything above it
        nc = '0;
        for (int j = 1; j <= MAX_KEEP; j++)
        begin
            pop_ok[j-1] = (held_reg[j-1] < d) &&
                          ((17'(rem) + 17'(j - 1)) >= 17'(k_eff));
            if ((CW'(j) <= count_reg) && !pop_ok[j-1])
            begin
                nc = CW'(j);
            end
        end

        base     = (nc == '0) ? '0 : pref_reg[IW'(nc - CW'(1))];
        new_val  = (base << 3) + (base << 1) + VALUE_W'(d);
        push     = nc < k_eff;
        line_val = push ? new_val : base;

        if (last)
        begin
            count_next = '0;
            pos_next   = '0;
        end
        else
        begin
            count_next = push ? (nc + CW'(1)) : nc;
            pos_next   = pos_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_adv)
            begin
                res_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                count_reg     <= count_next;
                pos_reg       <= pos_next;
                res_valid_reg <= last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && push)
        begin
            held_reg[IW'(nc)] <= d;
            pref_reg[IW'(nc)] <= new_val;
        end
        if (adv && last)
        begin
            res_value_reg <= line_val;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.value = res_value_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEEP))
        else $error("held count above stack depth");

    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        adv && last |=> (count_reg == '0) && (pos_reg == '0))
        else $error("line end did not clear stack state");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !out_ready |=> res_valid_reg && $stable(res_value_reg))
        else $error("pending line result lost");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/msp_total.sv =====
// ----------------------------------------------------------------------------
// msp_total
// saturating running total and output word register
// ----------------------------------------------------------------------------
`default_nettype none

module msp_total
    import msp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  res_t                     res,
    output logic                     ready,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [VALUE_W-1:0]  line_value,
    output logic      [TOTAL_W-1:0]  running_total
);

    logic               out_valid_reg;
    logic [VALUE_W-1:0] line_value_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W:0]   sum;
    logic               load;

    assign ready = !out_valid_reg || !out_stall;
    assign load  = res.valid && ready;

    always_comb
    begin
        sum        = {1'b0, total_reg} + (TOTAL_W + 1)'(res.value);
        total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else if (ready)
        begin
            out_valid_reg <= res.valid;
            if (load)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            line_value_reg <= res.value;
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_value    = line_value_reg;
    assign running_total = total_reg;

`ifndef SYNTHESIS
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_reg >= $past(total_reg))
        else $error("running total went down");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg && (line_value_reg == $past(res.value)))
        else $error("line result not presented");
`endif

endmodule

`default_nettype wire

// ===== tb/max_digit_subsequence_picker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_digit_subsequence_picker_checker
// Watches the register port and both word channels of the picker. Keeps its
// own greedy digit stack, line position and saturating total, forms the
// expected line word for every line end and compares each output word with
// the oldest one waiting.
// ----------------------------------------------------------------------------

module max_digit_subsequence_picker_checker
    import msp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [APB_W-1:0]   pwdata,
    input  wire logic               pready,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [DIGIT_W-1:0] digit,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [VALUE_W-1:0] line_value,
    input  wire logic [TOTAL_W-1:0] running_total,
    output int                      mismatches,
    output int                      lines_pending,
    output int                      lines_checked
);

    localparam int STACK_DEPTH = 16;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [TOTAL_W-1:0] total;
    } line_word_t;

    cfg_t               cfg;
    logic [DIGIT_W-1:0] held [STACK_DEPTH];
    int                 held_cnt;
    logic [LEN_W-1:0]   pos;
    logic [TOTAL_W-1:0] total;
    line_word_t         expected_lines [$];
    int                 n_bad;
    int                 n_checked;

    task automatic take_digit(input logic [DIGIT_W-1:0] d_in);
        logic [DIGIT_W-1:0] d;
        int                 len;
        int                 keep;
        int                 rem;
        bit                 last;
        int                 i;
        line_word_t         w;
        d    = (d_in > MAX_DIGIT) ? MAX_DIGIT : d_in;
        len  = (cfg.line_length == '0) ? 1 : int'(cfg.line_length);
        keep = (cfg.keep_count == '0) ? 1 :
               (cfg.keep_count > STACK_DEPTH) ? STACK_DEPTH : int'(cfg.keep_count);
        last = (int'(pos) >= len - 1);
        rem  = last ? 1 : len - int'(pos);
        while (held_cnt > 0 && held[held_cnt-1] < d && held_cnt - 1 + rem >= keep)
        begin
            held_cnt--;
        end
        if (held_cnt < keep && held_cnt < STACK_DEPTH)
        begin
            held[held_cnt] = d;
            held_cnt++;
        end
        if (!last)
        begin
            pos = pos + 1'b1;
        end
        else
        begin
            w.value = '0;
            for (i = 0; i < held_cnt; i++)
            begin
                w.value = w.value * VALUE_W'(10) + VALUE_W'(held[i]);
            end
            if (total > {TOTAL_W{1'b1}} - TOTAL_W'(w.value))
                total = {TOTAL_W{1'b1}};
            else
                total = total + TOTAL_W'(w.value);
            w.total = total;
            expected_lines.push_back(w);
            for (i = 0; i < STACK_DEPTH; i++)
            begin
                held[i] = '0;
            end
            held_cnt = 0;
            pos      = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        line_word_t w;
        int         i;
        if (!rst_n)
        begin
            cfg.line_length = LINE_LENGTH_RESET;
            cfg.keep_count  = KEEP_COUNT_RESET;
            for (i = 0; i < STACK_DEPTH; i++)
            begin
                held[i] = '0;
            end
            held_cnt  = 0;
            pos       = '0;
            total     = '0;
            n_bad     = 0;
            n_checked = 0;
            expected_lines.delete();
            mismatches    <= 0;
            lines_pending <= 0;
            lines_checked <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_lines.size() == 0)
                begin
                    $display("%0t: line word with none expected, value %0d total %0d",
                             $time, line_value, running_total);
                    n_bad++;
                end
                else
                begin
                    w = expected_lines.pop_front();
                    if (line_value !== w.value)
                    begin
                        $display("%0t: line_value expected %0d got %0d",
                                 $time, w.value, line_value);
                        n_bad++;
                    end
                    if (running_total !== w.total)
                    begin
                        $display("%0t: running_total expected %0d got %0d",
                                 $time, w.total, running_total);
                        n_bad++;
                    end
                    n_checked++;
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_LINE_LENGTH: cfg.line_length = pwdata[LEN_W-1:0];
                    REG_KEEP_COUNT:  cfg.keep_count  = pwdata[KEEP_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                take_digit(digit);
            mismatches    <= n_bad;
            lines_pending <= expected_lines.size();
            lines_checked <= n_checked;
        end
    end

endmodule

// ===== tb/max_digit_subsequence_picker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_digit_subsequence_picker_tb
// Drives digit words and register writes into the picker: a short directed
// set of lines, phases over many line and keep settings, all but the last with
// random gaps and output stalls, then two full lines of nines and above. The
// checker beside the block does the comparing; this module gives the verdict.
// ----------------------------------------------------------------------------

module max_digit_subsequence_picker_tb;
    import msp_pkg::*;

    localparam int LATENCY     = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 12;
    localparam int CLIMB_LINES = 2;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [ADDR_W-1:0]  paddr     = '0;
    logic [APB_W-1:0]   pwdata    = '0;
    logic [APB_W-1:0]   prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [DIGIT_W-1:0] digit     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [VALUE_W-1:0] line_value;
    logic [TOTAL_W-1:0] running_total;

    int          mismatches;
    int          lines_pending;
    int          lines_checked;
    int          digits_sent = 0;
    bit          steady      = 1'b0;
    int unsigned cycles      = 0;

    int phase_len   [PHASES] = '{100, 16, 20, 1, 65535, 10, 7, 3, 12, 18, 0, 40};
    int phase_keep  [PHASES] = '{12, 16, 5, 1, 1, 3, 3, 8, 0, 31, 16, 10};
    int phase_items [PHASES] = '{220, 160, 200, 60, 40, 100, 200, 90, 60, 90, 30, 200};

    max_digit_subsequence_picker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .digit         (digit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_value    (line_value),
        .running_total (running_total)
    );

    max_digit_subsequence_picker_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .digit         (digit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_value    (line_value),
        .running_total (running_total),
        .mismatches    (mismatches),
        .lines_pending (lines_pending),
        .lines_checked (lines_checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 32);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("max_digit_subsequence_picker_tb failed");
            $finish;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [APB_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // upper bits carry noise, the block keeps only the register width
    task automatic set_regs(input int len, input int keep);
        reg_write(REG_LINE_LENGTH, ($urandom() & 32'hFFFF_0000) | APB_W'(len));
        reg_write(REG_KEEP_COUNT, ($urandom() & 32'hFFFF_FFE0) | APB_W'(keep));
    endtask

    task automatic send_digit(input logic [DIGIT_W-1:0] d);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 32)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        digit    <= d;
        do @(posedge clk); while (in_stall);
        digits_sent++;
    endtask

    // wait out the pipe, every pending line word, then the pipe again
    task automatic drain();
        in_valid <= 1'b0;
        repeat (LATENCY) @(posedge clk);
        while (lines_pending != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // runs of one digit shape: uniform, near ties, rising, low, falling
    task automatic send_random(input int n);
        int                 i;
        int                 shape;
        int                 run;
        int                 step;
        logic [DIGIT_W-1:0] d;
        run   = 0;
        shape = 0;
        step  = 0;
        for (i = 0; i < n; i++)
        begin
            if (run == 0)
            begin
                shape = $urandom_range(0, 4);
                run   = $urandom_range(1, 30);
                step  = 0;
            end
            case (shape)
                0:       d = DIGIT_W'($urandom_range(0, 15));
                1:       d = DIGIT_W'($urandom_range(8, 9));
                2:       d = DIGIT_W'(step % 10);
                3:       d = DIGIT_W'($urandom_range(0, 3));
                default: d = DIGIT_W'(9 - step % 10);
            endcase
            send_digit(d);
            run--;
            step++;
        end
    endtask

    initial
    begin
        int p;
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, line left open and closed by a shorter length
        send_digit(4'd4); send_digit(4'd2); send_digit(4'd8);
        drain();
        set_regs(1, 1);
        send_digit(4'd0); send_digit(4'd9); send_digit(4'd15);
        drain();
        // ties keep the earliest nine, then a rising line
        set_regs(5, 3);
        send_digit(4'd9); send_digit(4'd9); send_digit(4'd1);
        send_digit(4'd9); send_digit(4'd9);
        send_digit(4'd1); send_digit(4'd2); send_digit(4'd3);
        send_digit(4'd4); send_digit(4'd5);
        drain();
        // zero length and zero keep
        set_regs(0, 0);
        send_digit(4'd7); send_digit(4'd3);
        drain();
        // keep above the stack depth, line shorter than keep
        set_regs(3, 31);
        send_digit(4'd5); send_digit(4'd1); send_digit(4'd7);
        drain();
        // keep lowered in mid-line, after part of the line is held
        set_regs(6, 4);
        send_digit(4'd1); send_digit(4'd2); send_digit(4'd3);
        drain();
        reg_write(REG_KEEP_COUNT, APB_W'(2));
        send_digit(4'd9); send_digit(4'd0); send_digit(4'd0);

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            set_regs(phase_len[p], phase_keep[p]);
            if (p == PHASES - 1)
                steady <= 1'b1;
            send_random(phase_items[p]);
            steady <= 1'b0;
        end
        drain();

        // full lines of nines and above, then a random tail
        set_regs(16, 16);
        for (i = 0; i < CLIMB_LINES * 16; i++)
        begin
            send_digit(DIGIT_W'($urandom_range(9, 15)));
        end
        send_random(48);
        drain();

        $display("covered %0d digits and %0d line words over %0d random settings",
                 digits_sent, lines_checked, PHASES);
        $display("with directed corner lines, mid-line writes and full-depth lines of nines");
        if (mismatches == 0 && lines_pending == 0)
            $display("max_digit_subsequence_picker_tb passed");
        else
            $display("max_digit_subsequence_picker_tb failed");
        $finish;
    end

endmodule
